### rtl/core/generational_slot_allocator_defines.svh
// Assertion macros for the generational slot allocator RTL.
// Depends on nothing; files that assert include it by name.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define GSA_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GSA_ASSERT(name, expr, msg)
`define GSA_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### rtl/core/gsa_pkg.sv
// Package for the generational slot allocator: sizes, codes and transaction types.
// Used by the controller and the top level.
`default_nettype none

package gsa_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = 8;
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 16;

    localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_QUERY       = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_NOT_ALIVE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_BUMP
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [SLOT_W-1:0] handle_slot;
        logic [GEN_W-1:0]  handle_generation;
    } gsa_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] granted_slot;
        logic [GEN_W-1:0]  granted_generation;
        logic              is_alive;
    } gsa_rsp_t;

    // Generation memory access from the controller
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [GEN_W-1:0]  wdata;
    } gsa_gen_mem_t;

    // Free stack memory access from the controller
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
    } gsa_stk_mem_t;

endpackage

`default_nettype wire

### rtl/core/gsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gsa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/gsa_ctrl.sv
// Controller of the generational slot allocator: sequencer, free count,
// top-of-stack cache and result register. Uses gsa_pkg and the defines header.
`default_nettype none

`include "generational_slot_allocator_defines.svh"

module gsa_ctrl
    import gsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_stall,
    input  wire gsa_req_t          req_data,
    output      logic              rsp_valid,
    input  wire logic              rsp_stall,
    output      gsa_rsp_t          rsp_data,
    output      gsa_gen_mem_t      gen_mem,
    input  wire logic [GEN_W-1:0]  gen_rdata,
    output      gsa_stk_mem_t      stk_mem,
    input  wire logic [SLOT_W-1:0] stk_rdata
);

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]  tos_reg, tos_next;
    gsa_req_t           item_reg, item_next;
    logic               rsp_valid_reg, rsp_valid_next;
    gsa_rsp_t           rsp_reg, rsp_next;

    logic               rsp_free;
    logic               rsp_load;
    logic               count_zero;
    logic               count_full;
    logic               slot_in_range;
    logic               alive;
    logic               idx_last;
    logic [SLOT_W-1:0]  idx_fill;
    logic [COUNT_W-1:0] count_m2;

    // Status terms
    assign rsp_free      = !rsp_valid_reg || !rsp_stall;
    assign count_zero    = (count_reg == '0);
    assign count_full    = (count_reg == COUNT_W'(SLOT_COUNT));
    assign slot_in_range = ({1'b0, item_reg.handle_slot} < COUNT_W'(SLOT_COUNT));
    assign alive         = (item_reg.handle_generation != '0) && slot_in_range
                           && (gen_rdata == item_reg.handle_generation);
    assign idx_last      = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign idx_fill      = SLOT_W'(SLOT_COUNT - 1) - idx_reg;
    assign count_m2      = count_reg - COUNT_W'(2);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Next state, memory accesses and result
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        tos_next       = tos_reg;
        item_next      = item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rsp_load       = 1'b0;
        gen_mem        = '0;
        stk_mem        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Post-reset init: generation 1, stack descending
                gen_mem.we    = 1'b1;
                gen_mem.waddr = idx_reg;
                gen_mem.wdata = GEN_INIT;
                stk_mem.we    = 1'b1;
                stk_mem.waddr = idx_reg;
                stk_mem.wdata = idx_fill;
                if (idx_last)
                begin
                    state_next = S_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next     = req_data;
                    gen_mem.re    = 1'b1;
                    gen_mem.raddr = (req_data.operation == OP_ALLOC) ? tos_reg
                                                                     : req_data.handle_slot;
                    // Entry below the top refreshes the cache after a pop
                    stk_mem.re    = 1'b1;
                    stk_mem.raddr = count_m2[SLOT_W-1:0];
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (rsp_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    state_next     = S_IDLE;
                    case (item_reg.operation)
                        OP_ALLOC:
                        begin
                            if (count_zero)
                            begin
                                rsp_next.status = STATUS_EXHAUSTED;
                            end
                            else
                            begin
                                rsp_next.status             = STATUS_OK;
                                rsp_next.granted_slot       = tos_reg;
                                rsp_next.granted_generation = gen_rdata;
                                count_next                  = count_reg - COUNT_W'(1);
                                tos_next                    = stk_rdata;
                            end
                        end

                        OP_RELEASE:
                        begin
                            rsp_next.is_alive = alive;
                            if (alive && !count_full)
                            begin
                                rsp_next.status = STATUS_OK;
                                gen_mem.we      = 1'b1;
                                gen_mem.waddr   = item_reg.handle_slot;
                                gen_mem.wdata   = gen_rdata + GEN_W'(1);
                                stk_mem.we      = 1'b1;
                                stk_mem.waddr   = count_reg[SLOT_W-1:0];
                                stk_mem.wdata   = item_reg.handle_slot;
                                count_next      = count_reg + COUNT_W'(1);
                                tos_next        = item_reg.handle_slot;
                            end
                            else
                            begin
                                rsp_next.status = STATUS_NOT_ALIVE;
                            end
                        end

                        OP_QUERY:
                        begin
                            rsp_next.is_alive = alive;
                            rsp_next.status   = alive ? STATUS_OK : STATUS_NOT_ALIVE;
                        end

                        OP_RELEASE_ALL:
                        begin
                            rsp_next.status = STATUS_OK;
                            gen_mem.re      = 1'b1;
                            gen_mem.raddr   = '0;
                            idx_next        = '0;
                            state_next      = S_BUMP;
                        end

                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_BUMP:
            begin
                // Read-modify-write sweep, one slot per cycle
                gen_mem.we    = 1'b1;
                gen_mem.waddr = idx_reg;
                gen_mem.wdata = gen_rdata + GEN_W'(1);
                stk_mem.we    = 1'b1;
                stk_mem.waddr = idx_reg;
                stk_mem.wdata = idx_fill;
                if (idx_last)
                begin
                    state_next = S_IDLE;
                    idx_next   = '0;
                    count_next = COUNT_W'(SLOT_COUNT);
                    tos_next   = '0;
                end
                else
                begin
                    idx_next      = idx_reg + SLOT_W'(1);
                    gen_mem.re    = 1'b1;
                    gen_mem.raddr = idx_reg + SLOT_W'(1);
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            count_reg     <= COUNT_W'(SLOT_COUNT);
            tos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            tos_reg       <= tos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    // Checks
    `GSA_ASSERT(a_count_bound, count_reg <= COUNT_W'(SLOT_COUNT), "free count above pool size")
    `GSA_ASSERT(a_push_bumps_gen, !stk_mem.we || gen_mem.we, "stack write without generation write")
    `GSA_ASSERT(a_load_in_exec, !rsp_load || state_reg == S_EXEC, "result loaded outside execute")
    `GSA_ASSERT_NEXT(a_pop_count, rsp_load && item_reg.operation == OP_ALLOC && !count_zero, count_reg == $past(count_reg) - COUNT_W'(1), "allocate did not pop")
    `GSA_ASSERT_NEXT(a_hold_result, rsp_valid_reg && rsp_stall, rsp_valid_reg && $stable(rsp_reg), "stalled result lost")

endmodule

`default_nettype wire

### rtl/core/generational_slot_allocator.sv
// Top level of the generational slot allocator: controller plus the
// generation and free stack memories. Uses gsa_pkg, gsa_ctrl and gsa_ram.
//
// Usage:
//   Requests arrive on req_valid / req_stall / req_data (operation, slot,
//   generation); one result per request leaves on rsp_valid / rsp_stall /
//   rsp_data. A transaction completes when valid is high and stall is low.
//   Allocate, release and query issue the registered memory read, then
//   update and load the result register once it is free, so the request
//   side takes no new request until the result register is loaded.
//   Release-all loads its result the same way, then sweeps every slot
//   through the generation memory read-modify-write, one slot per cycle,
//   and refills the free stack; the next request is taken when it ends.
//   After reset a clearing pass over all SLOT_COUNT slots (256) fills the
//   memories; requests are stalled until it ends.
//   The result register frees the request side: a request is taken while
//   a result waits, and that request holds in execute until the receiver
//   stops stalling.
`default_nettype none

module generational_slot_allocator
    import gsa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output      logic     req_stall,
    input  wire gsa_req_t req_data,
    output      logic     rsp_valid,
    input  wire logic     rsp_stall,
    output      gsa_rsp_t rsp_data
);

    gsa_gen_mem_t      gen_mem;
    gsa_stk_mem_t      stk_mem;
    logic [GEN_W-1:0]  gen_rdata;
    logic [SLOT_W-1:0] stk_rdata;

    // Sequencer and result register
    gsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .gen_mem   (gen_mem),
        .gen_rdata (gen_rdata),
        .stk_mem   (stk_mem),
        .stk_rdata (stk_rdata)
    );

    // Per-slot generation counters
    gsa_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (GEN_W)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_mem.we),
        .waddr (gen_mem.waddr),
        .wdata (gen_mem.wdata),
        .re    (gen_mem.re),
        .raddr (gen_mem.raddr),
        .rdata (gen_rdata)
    );

    // LIFO free stack
    gsa_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (SLOT_W)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_mem.we),
        .waddr (stk_mem.waddr),
        .wdata (stk_mem.wdata),
        .re    (stk_mem.re),
        .raddr (stk_mem.raddr),
        .rdata (stk_rdata)
    );

endmodule

`default_nettype wire

### tb/generational_slot_allocator_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the generational slot allocator: watches the request and result
// channels, predicts every result from its own copy of the slot state and compares.
// Depends on gsa_pkg only.

module generational_slot_allocator_checker
    import gsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  gsa_req_t    req_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  gsa_rsp_t    rsp_data,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned results_checked,
    output int unsigned exhausted_seen,
    output int unsigned refused_seen
);

    // Shadow copy of the pool: LIFO of free slots and the generation table
    logic [SLOT_W-1:0]  free_slots [SLOT_COUNT];
    logic [COUNT_W-1:0] free_depth;
    logic [GEN_W-1:0]   slot_gen   [SLOT_COUNT];

    gsa_rsp_t results_due [$];

    // Descending refill so that slot 0 sits on top
    function automatic void refill_free_slots();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            free_slots[i] = SLOT_W'(SLOT_COUNT - 1 - i);
        end
        free_depth = COUNT_W'(SLOT_COUNT);
    endfunction

    function automatic gsa_rsp_t predict_result(input gsa_req_t req);
        gsa_rsp_t          rsp;
        logic              alive;
        logic [SLOT_W-1:0] popped;

        rsp   = '0;
        alive = (req.handle_generation != '0)
             && (int'(req.handle_slot) < SLOT_COUNT)
             && (slot_gen[req.handle_slot] == req.handle_generation);

        case (req.operation)
            OP_ALLOC:
            begin
                if (free_depth == '0)
                begin
                    rsp.status = STATUS_EXHAUSTED;
                end
                else
                begin
                    free_depth             = free_depth - 1'b1;
                    popped                 = free_slots[free_depth];
                    rsp.granted_slot       = popped;
                    rsp.granted_generation = slot_gen[popped];
                end
            end
            OP_RELEASE:
            begin
                rsp.is_alive = alive;
                // refused when dead, or when the stack is already full
                if (!alive || free_depth >= COUNT_W'(SLOT_COUNT))
                begin
                    rsp.status = STATUS_NOT_ALIVE;
                end
                else
                begin
                    slot_gen[req.handle_slot] = slot_gen[req.handle_slot] + 1'b1;
                    free_slots[free_depth]    = req.handle_slot;
                    free_depth                = free_depth + 1'b1;
                end
            end
            OP_QUERY:
            begin
                rsp.is_alive = alive;
                rsp.status   = alive ? STATUS_OK : STATUS_NOT_ALIVE;
            end
            OP_RELEASE_ALL:
            begin
                refill_free_slots();
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    slot_gen[i] = slot_gen[i] + 1'b1;
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string field, input logic [GEN_W-1:0] want,
                               input logic [GEN_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Results are compared before the request of the same edge is predicted:
    // a result can never belong to a request accepted at that edge.
    always @(posedge clk or negedge rst_n)
    begin
        gsa_rsp_t want;

        if (!rst_n)
        begin
            refill_free_slots();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_gen[i] = GEN_INIT;
            end
            results_due.delete();
            pending         = 0;
            mismatches      = 0;
            results_checked = 0;
            exhausted_seen  = 0;
            refused_seen    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d slot %0d gen 0x%0h alive %0b",
                             $time, rsp_data.status, rsp_data.granted_slot,
                             rsp_data.granted_generation, rsp_data.is_alive);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", GEN_W'(want.status), GEN_W'(rsp_data.status));
                    check_field("granted_slot", GEN_W'(want.granted_slot),
                                GEN_W'(rsp_data.granted_slot));
                    check_field("granted_generation", want.granted_generation,
                                rsp_data.granted_generation);
                    check_field("is_alive", GEN_W'(want.is_alive), GEN_W'(rsp_data.is_alive));
                    results_checked++;
                    if (want.status == STATUS_EXHAUSTED)
                    begin
                        exhausted_seen++;
                    end
                    if (want.status == STATUS_NOT_ALIVE)
                    begin
                        refused_seen++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                results_due.insert(results_due.size(), predict_result(req_data));
            end
            pending = results_due.size();
        end
    end

endmodule

### tb/generational_slot_allocator_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the generational slot allocator: directed cases, random
// traffic of all four operations under varying idle and stall, and a generation walk.
// Depends on gsa_pkg, the allocator RTL and generational_slot_allocator_checker.

module generational_slot_allocator_test;
    import gsa_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
    } handle_t;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned WALK_ROUNDS = 12;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    gsa_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    gsa_rsp_t rsp_data;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned exhausted_seen;
    int unsigned refused_seen;

    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    logic        hold_req    = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned op_count [4];

    // Handles granted so far, gathered from the result channel
    handle_t held [$];
    handle_t last_grant;

    generational_slot_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    generational_slot_allocator_checker slot_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_data        (req_data),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp_data        (rsp_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .exhausted_seen  (exhausted_seen),
        .refused_seen    (refused_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off each time hold_req toggles
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Collect successful grants; release-all results carry generation zero
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall && rsp_data.status == STATUS_OK
            && !rsp_data.is_alive && rsp_data.granted_generation != '0)
        begin
            last_grant = {rsp_data.granted_slot, rsp_data.granted_generation};
            held.insert(held.size(), last_grant);
        end
    end

    function automatic logic [GEN_W-1:0] pick_gen();
        // small values hit live handles, full range toggles every bit
        if ($urandom_range(1) == 0)
        begin
            return GEN_W'($urandom_range(4));
        end
        return GEN_W'($urandom);
    endfunction

    // One transaction on the request channel; called and returns at a falling edge
    task automatic issue(input op_t op, input logic [SLOT_W-1:0] slot,
                         input logic [GEN_W-1:0] gen);
        gsa_req_t req;

        req.operation         = op;
        req.handle_slot       = slot;
        req.handle_generation = gen;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        op_count[op]++;
        items_sent++;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Sender pause until every expected result has come back
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Mostly a handle that was granted, sometimes left in the pool for a
    // later stale use, otherwise a random one
    task automatic draw_handle(input bit consume, output handle_t h);
        int unsigned idx;

        if (held.size() != 0 && $urandom_range(99) < 85)
        begin
            idx = $urandom_range(held.size() - 1);
            h   = held[idx];
            if (consume && $urandom_range(9) != 0)
            begin
                held.delete(idx);
            end
        end
        else
        begin
            h.slot = SLOT_W'($urandom);
            h.gen  = pick_gen();
        end
    endtask

    task automatic random_step();
        handle_t     h;
        int unsigned pick;
        int unsigned n;

        pick = $urandom_range(99);
        if (pick < 4)
        begin
            // allocation burst
            n = $urandom_range(16, 96);
            repeat (n) issue(OP_ALLOC, SLOT_W'($urandom), pick_gen());
        end
        else if (pick < 8)
        begin
            // release burst
            n = (held.size() < 64) ? held.size() : 64;
            repeat (n)
            begin
                draw_handle(1'b1, h);
                issue(OP_RELEASE, h.slot, h.gen);
            end
        end
        else if (pick < 10)
        begin
            issue(OP_RELEASE_ALL, SLOT_W'($urandom), pick_gen());
            held.delete();
        end
        else if (pick < 50)
        begin
            issue(OP_ALLOC, SLOT_W'($urandom), pick_gen());
        end
        else if (pick < 78)
        begin
            draw_handle(1'b1, h);
            issue(OP_RELEASE, h.slot, h.gen);
        end
        else
        begin
            draw_handle(1'b0, h);
            issue(OP_QUERY, h.slot, h.gen);
        end
    endtask

    initial
    begin
        handle_t           h;
        logic [SLOT_W-1:0] walk_slot;
        logic [GEN_W-1:0]  walk_gen;
        int unsigned       phase_start;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: basic grant/release, dead and zero handles, a free slot's
        // current generation counting as alive, release into a full stack
        issue(OP_ALLOC, '0, '0);
        issue(OP_ALLOC, '0, '0);
        issue(OP_QUERY, 8'd0, 16'd1);
        issue(OP_QUERY, 8'd0, 16'd0);
        issue(OP_QUERY, 8'hFF, 16'hFFFF);
        issue(OP_RELEASE, 8'd0, 16'd1);
        issue(OP_RELEASE, 8'd0, 16'd1);
        issue(OP_QUERY, 8'd0, 16'd1);
        issue(OP_QUERY, 8'd0, 16'd2);
        issue(OP_RELEASE, 8'd5, 16'd1);
        issue(OP_RELEASE, 8'd1, 16'd1);
        issue(OP_ALLOC, '0, '0);
        issue(OP_RELEASE_ALL, '0, '0);
        issue(OP_ALLOC, '0, '0);
        issue(OP_QUERY, 8'd0, 16'd3);
        issue(OP_RELEASE, 8'd0, 16'd0);
        issue(OP_RELEASE, 8'hFF, 16'hFFFF);
        issue(OP_ALLOC, 8'hFF, 16'hFFFF);
        issue(OP_RELEASE_ALL, 8'hFF, 16'hFFFF);
        drain();
        held.delete();

        // Random phases: no idling, idle sender, stalling receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 57; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 57; end
                default: begin idle_pct = 19; stall_pct <= 19; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                random_step();
            end

            if (phase == 0)
            begin
                // Long hold-off while allocations keep coming: the pipeline
                // fills, input stalls, and the pool runs dry
                hold_req <= ~hold_req;
                repeat (264) issue(OP_ALLOC, SLOT_W'($urandom), pick_gen());
                drain();
                while (held.size() != 0)
                begin
                    h = held.pop_back();
                    issue(OP_RELEASE, h.slot, h.gen);
                end
            end
        end
        drain();

        // Generation walk: cycle one slot through release and allocate a few
        // times, then try its stale, current and zero handles
        idle_pct = 0;
        stall_pct <= 0;
        issue(OP_RELEASE_ALL, '0, '0);
        issue(OP_ALLOC, '0, '0);
        drain();
        walk_slot = last_grant.slot;
        walk_gen  = last_grant.gen;
        held.delete();
        repeat (WALK_ROUNDS)
        begin
            issue(OP_RELEASE, walk_slot, walk_gen);
            walk_gen = walk_gen + 1'b1;
            issue(OP_ALLOC, '0, '0);
        end
        held.delete();
        issue(OP_QUERY, walk_slot, walk_gen - 1'b1);
        issue(OP_QUERY, walk_slot, walk_gen);
        issue(OP_QUERY, walk_slot, '0);
        issue(OP_RELEASE, walk_slot, '0);
        issue(OP_QUERY, walk_slot, 16'hFFFF);
        issue(OP_RELEASE_ALL, '0, '0);
        issue(OP_ALLOC, '0, '0);

        drain();
        // the last release-all sweep ended before the final allocate was taken
        repeat (SLOT_COUNT + 64) @(negedge clk);

        $display("Sent %0d transactions: %0d allocate, %0d release, %0d query, %0d release-all",
                 items_sent, op_count[OP_ALLOC], op_count[OP_RELEASE], op_count[OP_QUERY],
                 op_count[OP_RELEASE_ALL]);
        $display("Checked %0d results: %0d pool exhausted, %0d refused, %0d mismatches",
                 results_checked, exhausted_seen, refused_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/gsa_pkg.sv
rtl/core/gsa_ram.sv
rtl/core/gsa_ctrl.sv
rtl/core/generational_slot_allocator.sv
tb/generational_slot_allocator_checker.sv
tb/generational_slot_allocator_test.sv
